// ===== rtl/bldc_pkg.sv =====
// Shared types, constants and helpers for the BLDC commutation and position control block.
// Used by bldc_ctrl, bldc_datapath and the top level; depends on nothing else.
package bldc_pkg;

    localparam logic [1:0] OP_EDGE   = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_TARGET = 2'd2;

    localparam logic [2:0] REG_ROTOR_ORIGIN = 3'd0;
    localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
    localparam logic [2:0] REG_PROP_GAIN    = 3'd2;
    localparam logic [2:0] REG_DERIV_GAIN   = 3'd3;
    localparam logic [2:0] REG_INTEG_GAIN   = 3'd4;
    localparam logic [2:0] REG_PWM_PERIOD   = 3'd5;

    localparam logic signed [2:0] LEAD_FWD  = 3'sb010;
    localparam logic signed [2:0] LEAD_REV  = 3'sb110;
    localparam logic signed [2:0] LEAD_KICK = 3'sb111;

    localparam logic [5:0] DRIVE_LUT [8] = '{6'h12, 6'h18, 6'h09, 6'h21,
                                             6'h24, 6'h06, 6'h00, 6'h00};
    localparam logic [2:0] ROTOR_LUT [8] = '{3'd7, 3'd5, 3'd3, 3'd4,
                                             3'd1, 3'd0, 3'd2, 3'd7};

    // x/10 = (x * RECIP) >> 35 for any 32-bit unsigned x
    localparam logic [63:0] DIV10_RECIP = 64'h0000_0000_CCCC_CCCD;
    localparam int          DIV10_SHIFT = 35;

    // speed term clamp, +-1000 in 1/256 units
    localparam logic signed [19:0] SPEED_CLAMP = 20'sd256000;

    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_EDGE,
        STEP_MISC,
        STEP_K1,
        STEP_K2,
        STEP_K3,
        STEP_K4,
        STEP_K5,
        STEP_K6,
        STEP_K7,
        STEP_K8,
        STEP_EMIT
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
    } bldc_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       out_free;
    } bldc_status_t;

    function automatic logic [5:0] drive_pattern_for(input logic [2:0]        rotor,
                                                     input logic [2:0]        origin,
                                                     input logic signed [2:0] lead);
        logic signed [4:0] s;
        logic [2:0]        idx;
        s = $signed({2'b00, rotor}) - $signed({2'b00, origin}) + 5'(lead) + 5'sd6;
        if (s < 0) begin
            idx = s[2:0];
        end else if (s >= 5'sd12) begin
            idx = 3'(s - 5'sd12);
        end else if (s >= 5'sd6) begin
            idx = 3'(s - 5'sd6);
        end else begin
            idx = s[2:0];
        end
        return DRIVE_LUT[idx];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        if (v > 42'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

// ===== rtl/bldc_commutation_position_control.sv =====
// BLDC six-step commutation with PID position control, top level.
// Instantiates bldc_ctrl and bldc_datapath; uses bldc_pkg.
//
// Input channel (s_valid/s_ready): one transaction per item; s_operation selects a
// sensor edge, a control tick or a set-target item (code 3 changes nothing).
// Output channel (m_valid/m_ready): exactly one result transaction per input item,
// in input order, held in an output register until taken.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_addr at once
// (0 rotor origin, 1 max speed, 2..4 gains, 5 pwm period); write only when idle.
// Sequencing: an edge or a set-target item passes decode, one datapath step and emit,
// which raises m_valid; a control tick walks the sequencer through one shared
// 34x17 multiplier, one divide-by-ten reciprocal multiply and one read and one write
// of the error history memory, one stage per cycle. One item is in work at a time,
// so a new item is taken only after the last result has been emitted.
// A stalled receiver holds the finished result in the output register; the
// sequencer waits in its last step and s_ready stays low until the slot frees.
// Reset (aresetn low, synchronous) restores register defaults, clears position,
// target, history sum and fill count, and sets all three leads to -2.
module bldc_commutation_position_control
    import bldc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int REPORT_EVERY  = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [2:0]         s_sensor_bits,
    input  logic signed [23:0] s_target_revs,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_drive_pattern,
    output logic [15:0]        m_pwm_width,
    output logic               m_report_valid,
    output logic signed [31:0] m_position,
    output logic signed [31:0] m_velocity,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata
);

    bldc_cmd_t    cmd;
    bldc_status_t status;

    bldc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bldc_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .REPORT_EVERY  (REPORT_EVERY)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_operation     (s_operation),
        .s_sensor_bits   (s_sensor_bits),
        .s_target_revs   (s_target_revs),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_pattern (m_drive_pattern),
        .m_pwm_width     (m_pwm_width),
        .m_report_valid  (m_report_valid),
        .m_position      (m_position),
        .m_velocity      (m_velocity)
    );

endmodule

// ===== rtl/bldc_ctrl.sv =====
// Sequencer for the BLDC block: accepts a transaction, steps the datapath, emits the result.
// Depends on bldc_pkg for command and status types.
module bldc_ctrl
    import bldc_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  bldc_status_t status,
    output bldc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EDGE,
        ST_MISC,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_K5,
        ST_K6,
        ST_K7,
        ST_K8,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.step   = STEP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (status.op)
                    OP_EDGE: state_next = ST_EDGE;
                    OP_TICK: state_next = ST_K1;
                    default: state_next = ST_MISC;
                endcase
            end
            ST_EDGE: begin
                cmd.step   = STEP_EDGE;
                state_next = ST_EMIT;
            end
            ST_MISC: begin
                cmd.step   = STEP_MISC;
                state_next = ST_EMIT;
            end
            ST_K1: begin cmd.step = STEP_K1; state_next = ST_K2; end
            ST_K2: begin cmd.step = STEP_K2; state_next = ST_K3; end
            ST_K3: begin cmd.step = STEP_K3; state_next = ST_K4; end
            ST_K4: begin cmd.step = STEP_K4; state_next = ST_K5; end
            ST_K5: begin cmd.step = STEP_K5; state_next = ST_K6; end
            ST_K6: begin cmd.step = STEP_K6; state_next = ST_K7; end
            ST_K7: begin cmd.step = STEP_K7; state_next = ST_K8; end
            ST_K8: begin cmd.step = STEP_K8; state_next = ST_EMIT; end
            ST_EMIT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.step   = STEP_EMIT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/bldc_datapath.sv =====
// Datapath of the BLDC block: config registers, rotor tracking, velocity, error,
// error history memory with running sum, shared gain multiplier and output register.
// Depends on bldc_pkg.
module bldc_datapath
    import bldc_pkg::*;
#(
    parameter int HISTORY_DEPTH = 10,
    parameter int REPORT_EVERY  = 10
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  bldc_cmd_t           cmd,
    output bldc_status_t        status,
    input  logic [1:0]          s_operation,
    input  logic [2:0]          s_sensor_bits,
    input  logic signed [23:0]  s_target_revs,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_addr,
    input  logic [15:0]         cfg_wdata,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_drive_pattern,
    output logic [15:0]         m_pwm_width,
    output logic                m_report_valid,
    output logic signed [31:0]  m_position,
    output logic signed [31:0]  m_velocity
);

    localparam int PTR_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int TC_W   = $clog2(REPORT_EVERY + 1);
    localparam int ESUM_W = 29 + PTR_W;
    localparam int MA_W   = (ESUM_W > 34) ? ESUM_W : 34;
    localparam int MP_W   = MA_W + 17;
    localparam int YR_W   = MP_W + 4;
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HISTORY_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
    localparam logic [TC_W-1:0]   TC_LAST   = TC_W'(REPORT_EVERY);

    // configuration
    logic [2:0]  rotor_origin_reg;
    logic [9:0]  max_speed_reg;
    logic [15:0] prop_gain_reg, deriv_gain_reg, integ_gain_reg, pwm_period_reg;

    // latched transaction
    logic [1:0]         op_reg;
    logic [2:0]         bits_reg;
    logic signed [23:0] tgt_in_reg;

    // control state
    logic [2:0]         last_rotor_reg;
    logic signed [31:0] pos_reg, cmd_pos_reg, prev_pos_reg, prev_err_reg;
    logic signed [23:0] target_reg;
    logic signed [2:0]  phase_lead_reg, speed_lead_reg, lead_sel_reg;
    logic [15:0]        pulse_width_reg;
    logic [TC_W-1:0]    tick_reg;
    logic [PTR_W-1:0]   wptr_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic signed [ESUM_W-1:0] esum_reg;

    // tick working registers
    logic signed [31:0]     vel_reg, err_reg, old_reg;
    logic [28:0]            q_reg;
    logic signed [MP_W-1:0] mul_reg;
    logic signed [19:0]     ys_reg;
    logic signed [YR_W-1:0] yr_reg, chosen_reg;

    // results waiting for the output register
    logic [5:0]         res_pattern_reg;
    logic               res_report_reg;
    logic signed [31:0] res_vel_reg;

    logic signed [31:0] hist_mem [HISTORY_DEPTH];

    assign status.op       = op_reg;
    assign status.out_free = !m_valid || m_ready;

    // sensor edge
    logic [2:0]        rotor;
    logic signed [3:0] rot_d;
    logic signed [31:0] pos_edge;
    always_comb begin
        rotor = ROTOR_LUT[bits_reg];
        rot_d = $signed({1'b0, rotor}) - $signed({1'b0, last_rotor_reg});
        if (rot_d == 4'sd5) begin
            pos_edge = pos_reg - 32'sd1;
        end else if (rot_d == -4'sd5) begin
            pos_edge = pos_reg + 32'sd1;
        end else begin
            pos_edge = pos_reg + 32'(rot_d);
        end
    end

    // velocity and position error
    logic signed [32:0] pos_diff, cmd_diff;
    logic signed [41:0] vel_wide, tgt6, err_num, err_q;
    always_comb begin
        pos_diff = $signed({pos_reg[31], pos_reg}) - $signed({prev_pos_reg[31], prev_pos_reg});
        vel_wide = (42'(pos_diff) <<< 3) + (42'(pos_diff) <<< 1);
        cmd_diff = $signed({cmd_pos_reg[31], cmd_pos_reg}) - $signed({pos_reg[31], pos_reg});
        tgt6     = (42'(target_reg) <<< 2) + (42'(target_reg) <<< 1);
        err_num  = (42'(cmd_diff) <<< 8) + tgt6;
        // round toward zero
        err_q    = (err_num < 0) ? ((err_num + 42'sd255) >>> 8) : (err_num >>> 8);
    end

    // divide by ten
    logic [31:0] err_mag;
    logic [63:0] div_prod;
    logic signed [31:0] hist_new;
    always_comb begin
        err_mag  = err_reg[31] ? 32'(-err_reg) : err_reg;
        div_prod = {32'b0, err_mag} * DIV10_RECIP;
        hist_new = err_reg[31] ? -$signed({3'b000, q_reg}) : $signed({3'b000, q_reg});
    end

    // shared gain multiplier
    logic [12:0]            ws;
    logic signed [32:0]     vel_mag;
    logic signed [MA_W-1:0] mul_a;
    logic [15:0]            mul_b;
    logic signed [16:0]     gain_s;
    logic signed [MP_W-1:0] mul_p;
    always_comb begin
        ws      = 13'(max_speed_reg) * 13'd6;
        vel_mag = vel_reg[31] ? -$signed({vel_reg[31], vel_reg}) : $signed({vel_reg[31], vel_reg});
        mul_a   = '0;
        mul_b   = '0;
        case (cmd.step)
            STEP_K2: begin
                mul_a = MA_W'($signed({1'b0, ws})) - MA_W'(vel_mag);
                mul_b = prop_gain_reg;
            end
            STEP_K3: begin
                mul_a = MA_W'(err_reg);
                mul_b = prop_gain_reg;
            end
            STEP_K4: begin
                mul_a = MA_W'(err_reg) - MA_W'(prev_err_reg);
                mul_b = deriv_gain_reg;
            end
            STEP_K5: begin
                mul_a = MA_W'(esum_reg);
                mul_b = integ_gain_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        gain_s = $signed({1'b0, mul_b});
        mul_p  = mul_a * gain_s;
    end

    // speed term
    logic signed [MP_W-1:0] ys_raw;
    logic signed [19:0]     ys_clamped;
    always_comb begin
        ys_raw = err_reg[31] ? -mul_reg : mul_reg;
        if (ys_raw > MP_W'(SPEED_CLAMP)) begin
            ys_clamped = SPEED_CLAMP;
        end else if (ys_raw < -MP_W'(SPEED_CLAMP)) begin
            ys_clamped = -SPEED_CLAMP;
        end else begin
            ys_clamped = ys_raw[19:0];
        end
    end

    // selection and pulse width
    logic signed [YR_W-1:0] mul_ext, ys_ext;
    logic                   pick_speed;
    logic [YR_W-1:0]        chosen_mag, pw_wide;
    logic [15:0]            pw_sat;
    logic                   kick;
    logic signed [2:0]      lead_fin;
    logic [TC_W-1:0]        tick_inc;
    always_comb begin
        mul_ext    = YR_W'(mul_reg);
        ys_ext     = YR_W'(ys_reg);
        pick_speed = vel_reg[31] ? (ys_ext >= yr_reg) : (ys_ext <= yr_reg);
        chosen_mag = chosen_reg[YR_W-1] ? YR_W'(-chosen_reg) : YR_W'(chosen_reg);
        pw_wide    = chosen_mag >> 8;
        pw_sat     = (pw_wide > YR_W'(pwm_period_reg)) ? pwm_period_reg : pw_wide[15:0];
        kick       = (vel_reg == 32'sd0) && ((err_reg >= 32'sd3) || (err_reg <= -32'sd3));
        lead_fin   = (kick && (lead_sel_reg == LEAD_REV)) ? LEAD_KICK : lead_sel_reg;
        tick_inc   = tick_reg + TC_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (cmd.step == STEP_K1) begin
            old_reg <= hist_mem[wptr_reg];
        end
        if (cmd.step == STEP_K3) begin
            hist_mem[wptr_reg] <= hist_new;
        end
    end

    always_ff @(posedge aclk) begin
        mul_reg <= mul_p;
        if (cmd.load) begin
            op_reg     <= s_operation;
            bits_reg   <= s_sensor_bits;
            tgt_in_reg <= s_target_revs;
        end
        case (cmd.step)
            STEP_K1: begin
                vel_reg <= sat32(vel_wide);
                err_reg <= sat32(err_q);
            end
            STEP_K2: q_reg <= div_prod[63:DIV10_SHIFT];
            STEP_K3: ys_reg <= (ws != 13'd0) ? ys_clamped : SPEED_CLAMP;
            STEP_K4: yr_reg <= mul_ext;
            STEP_K5: yr_reg <= yr_reg + (mul_ext <<< 3) + (mul_ext <<< 1);
            STEP_K6: yr_reg <= yr_reg + mul_ext;
            STEP_K7: chosen_reg <= pick_speed ? ys_ext : yr_reg;
            default: ;
        endcase
        if (cmd.step == STEP_EMIT) begin
            m_drive_pattern <= res_pattern_reg;
            m_pwm_width     <= pulse_width_reg;
            m_report_valid  <= res_report_reg;
            m_position      <= pos_reg;
            m_velocity      <= res_vel_reg;
        end

        if (!aresetn) begin
            rotor_origin_reg <= 3'd0;
            max_speed_reg    <= 10'd300;
            prop_gain_reg    <= 16'd3840;
            deriv_gain_reg   <= 16'd2816;
            integ_gain_reg   <= 16'd90;
            pwm_period_reg   <= 16'd2000;
            last_rotor_reg   <= '0;
            pos_reg          <= '0;
            cmd_pos_reg      <= '0;
            target_reg       <= '0;
            prev_pos_reg     <= '0;
            prev_err_reg     <= '0;
            phase_lead_reg   <= LEAD_REV;
            speed_lead_reg   <= LEAD_REV;
            lead_sel_reg     <= LEAD_REV;
            pulse_width_reg  <= '0;
            tick_reg         <= '0;
            wptr_reg         <= '0;
            fill_reg         <= '0;
            esum_reg         <= '0;
            res_pattern_reg  <= '0;
            res_report_reg   <= 1'b0;
            res_vel_reg      <= '0;
            m_valid          <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_ROTOR_ORIGIN: rotor_origin_reg <= cfg_wdata[2:0];
                    REG_MAX_SPEED:    max_speed_reg    <= cfg_wdata[9:0];
                    REG_PROP_GAIN:    prop_gain_reg    <= cfg_wdata;
                    REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_wdata;
                    REG_INTEG_GAIN:   integ_gain_reg   <= cfg_wdata;
                    REG_PWM_PERIOD:   pwm_period_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            case (cmd.step)
                STEP_EDGE: begin
                    res_pattern_reg <= drive_pattern_for(rotor, rotor_origin_reg,
                                                         phase_lead_reg);
                    pos_reg         <= pos_edge;
                    last_rotor_reg  <= rotor;
                    res_report_reg  <= 1'b0;
                    res_vel_reg     <= '0;
                end
                STEP_MISC: begin
                    if (op_reg == OP_TARGET) begin
                        target_reg  <= tgt_in_reg;
                        cmd_pos_reg <= pos_reg;
                    end
                    res_pattern_reg <= '0;
                    res_report_reg  <= 1'b0;
                    res_vel_reg     <= '0;
                end
                STEP_K3: begin
                    if (ws != 13'd0) begin
                        speed_lead_reg <= (ys_raw >= 0) ? LEAD_FWD : LEAD_REV;
                    end
                    // drop the oldest entry once the history is full
                    esum_reg <= esum_reg - ((fill_reg == FILL_FULL) ? ESUM_W'(old_reg) : '0)
                                         + ESUM_W'(hist_new);
                    wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + PTR_W'(1);
                    if (fill_reg != FILL_FULL) begin
                        fill_reg <= fill_reg + FILL_W'(1);
                    end
                end
                STEP_K7: begin
                    lead_sel_reg <= pick_speed ? speed_lead_reg
                                               : ((yr_reg >= 0) ? LEAD_FWD : LEAD_REV);
                end
                STEP_K8: begin
                    pulse_width_reg <= pw_sat;
                    phase_lead_reg  <= lead_fin;
                    res_pattern_reg <= kick ? drive_pattern_for(last_rotor_reg,
                                                                rotor_origin_reg, lead_fin)
                                            : 6'd0;
                    if (tick_inc >= TC_LAST) begin
                        tick_reg       <= '0;
                        res_report_reg <= 1'b1;
                    end else begin
                        tick_reg       <= tick_inc;
                        res_report_reg <= 1'b0;
                    end
                    prev_err_reg <= err_reg;
                    prev_pos_reg <= pos_reg;
                    res_vel_reg  <= vel_reg;
                end
                default: ;
            endcase
            if (cmd.step == STEP_EMIT) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for bldc_commutation_position_control.
// Drives random edges, ticks and targets, predicts each result in SV and compares it.
// Depends on rtl/bldc_pkg.sv and the block's RTL.
`timescale 1ns / 100ps

module testbench;
    import bldc_pkg::*;

    localparam int HIST_DEPTH  = 10;
    localparam int REPORT_RATE = 10;
    localparam int IDLE_LIMIT  = 5000;

    typedef struct packed {
        logic [1:0]         op;
        logic [2:0]         sensor;
        logic signed [23:0] target;
    } motor_item_t;

    typedef struct packed {
        logic [5:0]         drive;
        logic [15:0]        width;
        logic               report;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
    } motor_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic [2:0]         s_sensor_bits;
    logic signed [23:0] s_target_revs;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_drive_pattern;
    logic [15:0]        m_pwm_width;
    logic               m_report_valid;
    logic signed [31:0] m_position;
    logic signed [31:0] m_velocity;
    logic               cfg_wr_en;
    logic [2:0]         cfg_addr;
    logic [15:0]        cfg_wdata;

    bldc_commutation_position_control uut (.*);

    // predictor state and register copy
    logic [2:0]         cur_origin;
    logic [9:0]         cur_max_speed;
    logic [15:0]        cur_kp, cur_kd, cur_ki, cur_period;
    logic [2:0]         last_rotor;
    logic [31:0]        pos_count, cmd_pos, prev_pos;
    logic signed [23:0] target_latch;
    int                 prev_err;
    int                 err_hist [HIST_DEPTH];
    int                 drive_lead, spd_lead;
    logic [15:0]        held_width;
    int                 ticks_seen;

    motor_item_t   pending_items [$];
    motor_result_t expected_results [$];
    int            error_count;
    int            idle_cycles;
    logic          stimulus_done;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint magnitude(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic [5:0] commutation_pattern(input logic [2:0] rotor);
        int s;
        int r;
        s = int'(rotor) - int'(cur_origin) + drive_lead + 6;
        r = s % 6;
        return DRIVE_LUT[r & 7];
    endfunction

    task automatic reset_motor_model();
        cur_origin = 0; cur_max_speed = 300; cur_kp = 3840; cur_kd = 2816;
        cur_ki = 90; cur_period = 2000;
        last_rotor = 0; pos_count = 0; cmd_pos = 0; prev_pos = 0;
        target_latch = 0; prev_err = 0; held_width = 0; ticks_seen = 0;
        drive_lead = -2; spd_lead = -2;
        foreach (err_hist[i]) err_hist[i] = 0;
    endtask

    task automatic write_register(input logic [2:0] addr, input logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            REG_ROTOR_ORIGIN: cur_origin    = value[2:0];
            REG_MAX_SPEED:    cur_max_speed = value[9:0];
            REG_PROP_GAIN:    cur_kp        = value;
            REG_DERIV_GAIN:   cur_kd        = value;
            REG_INTEG_GAIN:   cur_ki        = value;
            REG_PWM_PERIOD:   cur_period    = value;
            default: ;
        endcase
    endtask

    // compute the result of one accepted transaction and advance the model
    task automatic predict_motor_step(input motor_item_t it);
        motor_result_t res;
        logic [2:0] rotor;
        int d;
        longint pos, cmd, tgt, ws, esum, ys, yr, chosen, pw;
        int vel, err, sgn, lead_r, lead;
        res = '0;
        if (it.op == OP_EDGE) begin
            rotor = ROTOR_LUT[it.sensor];
            d = int'(rotor) - int'(last_rotor);
            res.drive = commutation_pattern(rotor);
            if (d == 5) pos_count -= 1;
            else if (d == -5) pos_count += 1;
            else pos_count += 32'(d);
            last_rotor = rotor;
        end else if (it.op == OP_TICK) begin
            pos = longint'($signed(pos_count));
            cmd = longint'($signed(cmd_pos));
            tgt = longint'(target_latch);
            ws = longint'(cur_max_speed) * 6;
            vel = int'(sat_word((pos - longint'($signed(prev_pos))) * 10));
            err = int'(sat_word((tgt * 6 + (cmd - pos) * 256) / 256));
            sgn = err >= 0 ? 1 : -1;
            esum = 0;
            for (int i = HIST_DEPTH - 1; i > 0; i--) begin
                err_hist[i] = err_hist[i-1];
                esum += err_hist[i];
            end
            err_hist[0] = err / 10;
            esum += err_hist[0];
            ys = longint'(cur_kp) * (ws - magnitude(vel)) * sgn;
            yr = longint'(cur_kp) * err + longint'(cur_kd) * (longint'(err) - prev_err) * 10
               + longint'(cur_ki) * esum;
            lead_r = yr >= 0 ? 2 : -2;
            if (ws != 0) begin
                spd_lead = ys >= 0 ? 2 : -2;
                if (ys > 256000) ys = 256000;
                if (ys < -256000) ys = -256000;
            end else begin
                ys = 256000;
            end
            if (vel < 0) begin
                if (ys >= yr) begin chosen = ys; lead = spd_lead; end
                else begin chosen = yr; lead = lead_r; end
            end else begin
                if (ys <= yr) begin chosen = ys; lead = spd_lead; end
                else begin chosen = yr; lead = lead_r; end
            end
            pw = magnitude(chosen) / 256;
            if (pw > longint'(cur_period)) pw = longint'(cur_period);
            held_width = 16'(pw);
            drive_lead = lead;
            // kick-start from stand-still
            if (vel == 0 && (err >= 3 || err <= -3)) begin
                if (drive_lead == -2) drive_lead = -1;
                res.drive = commutation_pattern(last_rotor);
            end
            ticks_seen++;
            if (ticks_seen >= REPORT_RATE) begin
                ticks_seen = 0;
                res.report = 1'b1;
            end
            prev_err = err;
            prev_pos = pos_count;
            res.vel = vel;
        end else if (it.op == OP_TARGET) begin
            target_latch = it.target;
            cmd_pos = pos_count;
        end
        res.width = held_width;
        res.pos = pos_count;
        expected_results.push_back(res);
    endtask

    function automatic int gap_length();
        int p;
        p = $urandom_range(99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // input side driver
    int send_gap;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) predict_motor_step(
                '{op: s_operation, sensor: s_sensor_bits, target: s_target_revs});
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_items.size() > 0) begin
                    motor_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= it.op;
                    s_sensor_bits <= it.sensor;
                    s_target_revs <= it.target;
                    send_gap <= gap_length();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result side monitor
    int stall_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", 1, 0);
                end else begin
                    motor_result_t want;
                    want = expected_results.pop_front();
                    if (m_drive_pattern !== want.drive)
                        report_mismatch("drive_pattern", m_drive_pattern, want.drive);
                    if (m_pwm_width !== want.width)
                        report_mismatch("pwm_width", m_pwm_width, want.width);
                    if (m_report_valid !== want.report)
                        report_mismatch("report_valid", m_report_valid, want.report);
                    if (m_position !== want.pos)
                        report_mismatch("position", m_position, want.pos);
                    if (m_velocity !== want.vel)
                        report_mismatch("velocity", m_velocity, want.vel);
                end
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready <= 1'b1;
                stall_left <= gap_length();
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT && !stimulus_done) begin
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    function automatic motor_item_t make_item(input logic [1:0] op, input logic [2:0] sb,
                                              input logic signed [23:0] tg);
        motor_item_t it;
        it.op = op; it.sensor = sb; it.target = tg;
        return it;
    endfunction

    // hold until the block has drained all results, then let in-flight work settle
    task automatic drain_block();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // random phase: mostly a forward or backward rotation with ticks and targets
    task automatic queue_random_items(input int count);
        int step_dir;
        int phase;
        int seq_idx;
        logic [2:0] seq [6];
        seq = '{3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd1};
        step_dir = 1;
        seq_idx = 0;
        for (int n = 0; n < count; n++) begin
            phase = $urandom_range(99);
            if (phase < 3) step_dir = -step_dir;
            if (phase < 60) begin
                seq_idx = (seq_idx + step_dir + 6) % 6;
                pending_items.push_back(make_item(OP_EDGE, seq[seq_idx], 24'($urandom)));
            end else if (phase < 68) begin
                pending_items.push_back(make_item(OP_EDGE, 3'($urandom), 24'($urandom)));
            end else if (phase < 90) begin
                pending_items.push_back(make_item(OP_TICK, 3'($urandom), 24'($urandom)));
            end else if (phase < 96) begin
                pending_items.push_back(make_item(OP_TARGET, 3'($urandom),
                    ($urandom_range(3) == 0) ? 24'($urandom)
                                              : 24'($signed($urandom_range(8000)) - 4000)));
            end else begin
                pending_items.push_back(make_item(2'd3, 3'($urandom), 24'($urandom)));
            end
        end
    endtask

    initial begin
        error_count = 0;
        stimulus_done = 1'b0;
        aresetn = 1'b0;
        s_operation = '0; s_sensor_bits = '0; s_target_revs = '0;
        cfg_wr_en = 1'b0; cfg_addr = '0; cfg_wdata = '0;
        reset_motor_model();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: every sensor code, extreme targets, ticks, unused op
        for (int c = 0; c < 8; c++) pending_items.push_back(make_item(OP_EDGE, 3'(c), '0));
        pending_items.push_back(make_item(OP_TICK, 3'd7, 24'sh7FFFFF));
        pending_items.push_back(make_item(OP_TARGET, 3'd0, 24'sh7FFFFF));
        pending_items.push_back(make_item(OP_TICK, 3'd0, '0));
        pending_items.push_back(make_item(OP_TICK, 3'd0, '0));
        pending_items.push_back(make_item(OP_TARGET, 3'd7, 24'sh800000));
        pending_items.push_back(make_item(OP_TICK, 3'd0, '0));
        pending_items.push_back(make_item(2'd3, 3'd7, 24'shFFFFFF));
        pending_items.push_back(make_item(OP_TARGET, 3'd0, 24'sd256));
        for (int k = 0; k < 10; k++) pending_items.push_back(make_item(OP_TICK, 3'd0, '0));
        drain_block();

        // several register settings, extremes among them
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_register(REG_ROTOR_ORIGIN, 16'd7);
                    write_register(REG_MAX_SPEED, 16'd0);
                    write_register(REG_PROP_GAIN, 16'hFFFF);
                    write_register(REG_DERIV_GAIN, 16'hFFFF);
                    write_register(REG_INTEG_GAIN, 16'hFFFF);
                    write_register(REG_PWM_PERIOD, 16'hFFFF);
                end
                1: begin
                    write_register(REG_ROTOR_ORIGIN, 16'd0);
                    write_register(REG_MAX_SPEED, 16'd1023);
                    write_register(REG_PROP_GAIN, 16'd0);
                    write_register(REG_DERIV_GAIN, 16'd0);
                    write_register(REG_INTEG_GAIN, 16'd0);
                    write_register(REG_PWM_PERIOD, 16'd1);
                end
                2: begin
                    write_register(REG_PWM_PERIOD, 16'd0);
                    write_register(REG_PROP_GAIN, 16'd3840);
                end
                default: begin
                    write_register(REG_ROTOR_ORIGIN, 16'($urandom_range(7)));
                    write_register(REG_MAX_SPEED, 16'($urandom_range(1023)));
                    write_register(REG_PROP_GAIN, 16'($urandom));
                    write_register(REG_DERIV_GAIN, 16'($urandom_range(4000)));
                    write_register(REG_INTEG_GAIN, 16'($urandom_range(500)));
                    write_register(REG_PWM_PERIOD, 16'($urandom_range(65535, 1)));
                end
            endcase
            queue_random_items(100);
            drain_block();
        end

        stimulus_done = 1'b1;
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end
endmodule
